FILE: sv/assert_macros.svh
// assertion macros, included by the queue unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/i2cmcq_pkg.sv
// types and constants of the i2c master command queue
`timescale 1ns / 1ps
`default_nettype none

package i2cmcq_pkg;

    // request modes
    localparam logic [2:0] MODE_SELECT = 3'd0;
    localparam logic [2:0] MODE_SEND   = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_EVENT  = 3'd4;
    localparam logic [2:0] MODE_KICK   = 3'd5;

    localparam logic [7:0] NO_DEVICE = 8'hFF;

    typedef struct packed {
        logic master;
        logic transmit;
        logic nack;
    } t_bus_ctl;

    // one queue entry: bus control, repeated start mark, data byte
    typedef struct packed {
        t_bus_ctl   ctl;
        logic       restart;
        logic [7:0] data_byte;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_bus_ctl BUS_SEND      = '{master: 1'b1, transmit: 1'b1, nack: 1'b0};
    localparam t_bus_ctl BUS_READ      = '{master: 1'b1, transmit: 1'b0, nack: 1'b0};
    localparam t_bus_ctl BUS_READ_NACK = '{master: 1'b1, transmit: 1'b0, nack: 1'b1};
    localparam t_bus_ctl BUS_STOP      = '{master: 1'b0, transmit: 1'b0, nack: 1'b0};

endpackage

`default_nettype wire

FILE: sv/i2c_master_command_queue_unit.sv
// top level of the i2c master command queue: sequencer around the command ram
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  request  | in        | i_in_valid / o_in_ready | i_mode, i_slave, i_data, i_force_start,
//           |           |                         | i_optional, i_read_length, i_rx_byte
//  result   | out       | o_out_valid/i_out_ready | o_ctrl_*, o_tx_*, o_rx_*, o_busy_res,
//           |           |                         | o_dropped
//
//  states: select, send, stop and idle requests go from S_IDLE to S_FIN; a read request
//    passes S_PUSH2, as its read entry follows any address entry through the single ram
//    write port; a popping request passes S_POPRD (registered ram read), S_POP (decode)
//  one request is worked on at a time; the next is taken once the result sits in the
//    output register, even while that register still waits for i_out_ready
//  reset: synchronous, active low; the ram is not cleared, head and tail pointers
//    start equal so no unwritten entry is ever read
//  a stalled output only holds the sequencer in its final state; nothing is lost
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2c_master_command_queue_unit #(
    parameter int QUEUE_DEPTH = 512
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_slave,
    input  wire logic [7:0] i_data,
    input  wire logic       i_force_start,
    input  wire logic       i_optional,
    input  wire logic [7:0] i_read_length,
    input  wire logic [7:0] i_rx_byte,

    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_ctrl_write,
    output logic            o_ctrl_master,
    output logic            o_ctrl_transmit,
    output logic            o_ctrl_nack,
    output logic            o_ctrl_restart,
    output logic            o_tx_write,
    output logic [7:0]      o_tx_byte,
    output logic            o_rx_valid,
    output logic [7:0]      o_rx_out,
    output logic            o_rx_done,
    output logic            o_busy_res,
    output logic            o_dropped
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a request
        S_PUSH2,  // receive command write of a read request
        S_POPRD,  // check for empty queue, issue ram read at tail
        S_POP,    // ram data back, decode the entry
        S_FIN     // hand the result to the output register
    } t_state;

    // sequencer state
    t_state               r_state, n_state;
    logic [AW-1:0]        r_head, n_head;     // write index
    logic [AW-1:0]        r_tail, n_tail;     // read index
    logic [7:0]           r_sel, n_sel;       // selected device, NO_DEVICE for none
    logic                 r_restart, n_restart;
    logic                 r_skip, n_skip;
    logic                 r_running, n_running;
    logic                 r_receiving, n_receiving;
    logic [7:0]           r_bytes_left, n_bytes_left;
    logic [7:0]           r_pend_len, n_pend_len;
    i2cmcq_pkg::t_bus_ctl r_bus, n_bus;
    logic                 r_read_nack, n_read_nack;

    // per request result flags, built up while the request is worked on
    logic                 r_cw, n_cw;
    logic                 r_rst, n_rst;
    logic                 r_tw, n_tw;
    logic [7:0]           r_tx, n_tx;
    logic                 r_rv, n_rv;
    logic [7:0]           r_rx, n_rx;
    logic                 r_rd, n_rd;
    logic                 r_drop, n_drop;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_o_cw, n_o_cw;
    i2cmcq_pkg::t_bus_ctl r_o_bus, n_o_bus;
    logic                 r_o_rst, n_o_rst;
    logic                 r_o_tw, n_o_tw;
    logic [7:0]           r_o_tx, n_o_tx;
    logic                 r_o_rv, n_o_rv;
    logic [7:0]           r_o_rx, n_o_rx;
    logic                 r_o_rd, n_o_rd;
    logic                 r_o_busy, n_o_busy;
    logic                 r_o_drop, n_o_drop;

    // ram side
    logic                   w_push_req;
    i2cmcq_pkg::t_entry     w_push_ent;
    logic                   w_full;
    logic                   w_we;
    logic                   w_rd_en;
    logic [AW-1:0]          w_head_nxt;
    logic [AW-1:0]          w_tail_nxt;
    logic [i2cmcq_pkg::ENTRY_W-1:0] w_rd_raw;
    i2cmcq_pkg::t_entry     w_rd_ent;

    assign w_head_nxt = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_nxt = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_full     = (w_head_nxt == r_tail);
    assign w_rd_ent   = w_rd_raw;

    i2cmcq_ram #(
        .WIDTH (i2cmcq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (r_head),
        .i_wr_data (w_push_ent),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_tail),
        .o_rd_data (w_rd_raw)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_sel        = r_sel;
        n_restart    = r_restart;
        n_skip       = r_skip;
        n_running    = r_running;
        n_receiving  = r_receiving;
        n_bytes_left = r_bytes_left;
        n_pend_len   = r_pend_len;
        n_bus        = r_bus;
        n_read_nack  = r_read_nack;
        n_cw         = r_cw;
        n_rst        = r_rst;
        n_tw         = r_tw;
        n_tx         = r_tx;
        n_rv         = r_rv;
        n_rx         = r_rx;
        n_rd         = r_rd;
        n_drop       = r_drop;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_cw       = r_o_cw;
        n_o_bus      = r_o_bus;
        n_o_rst      = r_o_rst;
        n_o_tw       = r_o_tw;
        n_o_tx       = r_o_tx;
        n_o_rv       = r_o_rv;
        n_o_rx       = r_o_rx;
        n_o_rd       = r_o_rd;
        n_o_busy     = r_o_busy;
        n_o_drop     = r_o_drop;
        w_push_req   = 1'b0;
        w_push_ent   = '0;
        w_rd_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cw    = 1'b0;
                    n_rst   = 1'b0;
                    n_tw    = 1'b0;
                    n_tx    = '0;
                    n_rv    = 1'b0;
                    n_rx    = '0;
                    n_rd    = 1'b0;
                    n_drop  = 1'b0;
                    n_state = S_FIN;
                    case (i_mode)
                        i2cmcq_pkg::MODE_SELECT, i2cmcq_pkg::MODE_READ: begin
                            // address byte only on a new device or a forced start
                            if (i_slave != r_sel || i_force_start) begin
                                n_sel      = i_slave;
                                w_push_req = 1'b1;
                                w_push_ent = '{ctl: i2cmcq_pkg::BUS_SEND,
                                               restart: r_restart,
                                               data_byte: i_slave};
                                n_skip     = 1'b0;
                                n_restart  = 1'b1;
                            end else if (i_optional) begin
                                n_skip = 1'b1;
                            end else begin
                                n_skip    = 1'b0;
                                n_restart = 1'b1;
                            end
                            if (i_mode == i2cmcq_pkg::MODE_READ) begin
                                n_pend_len  = i_read_length;
                                n_read_nack = (i_read_length == 8'd1);
                                n_state     = S_PUSH2;
                            end
                        end
                        i2cmcq_pkg::MODE_SEND: begin
                            if (!r_skip) begin
                                w_push_req = 1'b1;
                                w_push_ent = '{ctl: i2cmcq_pkg::BUS_SEND,
                                               restart: 1'b0,
                                               data_byte: i_data};
                            end
                        end
                        i2cmcq_pkg::MODE_STOP: begin
                            n_sel      = i2cmcq_pkg::NO_DEVICE;
                            n_restart  = 1'b0;
                            n_skip     = 1'b0;
                            w_push_req = 1'b1;
                            w_push_ent = '{ctl: i2cmcq_pkg::BUS_STOP,
                                           restart: 1'b0,
                                           data_byte: 8'd0};
                        end
                        i2cmcq_pkg::MODE_EVENT: begin
                            if (r_receiving) begin
                                n_bytes_left = (r_bytes_left != 8'd0) ?
                                               r_bytes_left - 8'd1 : 8'd0;
                                n_rv = 1'b1;
                                n_rx = i_rx_byte;
                                if (r_bytes_left == 8'd2) begin
                                    n_bus.nack = 1'b1;
                                    n_cw       = 1'b1;
                                end
                                if (r_bytes_left <= 8'd1) begin
                                    // last byte: back to transmit, resume the queue
                                    n_bus.transmit = 1'b1;
                                    n_cw           = 1'b1;
                                    n_receiving    = 1'b0;
                                    n_rd           = 1'b1;
                                    n_state        = S_POPRD;
                                end
                            end else if (r_running) begin
                                n_state = S_POPRD;
                            end
                        end
                        i2cmcq_pkg::MODE_KICK: begin
                            if (!r_running && r_head != r_tail) begin
                                n_running = 1'b1;
                                n_state   = S_POPRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUSH2: begin
                w_push_req = 1'b1;
                w_push_ent = '{ctl: r_read_nack ? i2cmcq_pkg::BUS_READ_NACK
                                                : i2cmcq_pkg::BUS_READ,
                               restart: 1'b0,
                               data_byte: 8'd0};
                n_state    = S_FIN;
            end
            S_POPRD: begin
                if (r_head == r_tail) begin
                    n_running = 1'b0;
                    n_state   = S_FIN;
                end else begin
                    w_rd_en = 1'b1;
                    n_tail  = w_tail_nxt;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (w_rd_ent.ctl != r_bus || w_rd_ent.restart) begin
                    n_bus = w_rd_ent.ctl;
                    n_cw  = 1'b1;
                    n_rst = w_rd_ent.restart;
                end
                if (!w_rd_ent.ctl.master) begin
                    n_running = 1'b0;
                end else if (!w_rd_ent.ctl.transmit) begin
                    n_receiving  = 1'b1;
                    n_bytes_left = r_pend_len;
                end else begin
                    n_tw = 1'b1;
                    n_tx = w_rd_ent.data_byte;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_cw      = r_cw;
                    n_o_bus     = r_bus;
                    n_o_rst     = r_rst;
                    n_o_tw      = r_tw;
                    n_o_tx      = r_tx;
                    n_o_rv      = r_rv;
                    n_o_rx      = r_rx;
                    n_o_rd      = r_rd;
                    n_o_busy    = r_running;
                    n_o_drop    = r_drop;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // single ram write port; a full queue drops the entry and flags it
        w_we = w_push_req && !w_full;
        if (w_we) begin
            n_head = w_head_nxt;
        end
        n_drop = n_drop || (w_push_req && w_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_sel       <= i2cmcq_pkg::NO_DEVICE;
            r_restart   <= 1'b0;
            r_skip      <= 1'b0;
            r_running   <= 1'b0;
            r_receiving <= 1'b0;
            r_bytes_left <= '0;
            r_pend_len  <= '0;
            r_bus       <= i2cmcq_pkg::BUS_STOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_sel       <= n_sel;
            r_restart   <= n_restart;
            r_skip      <= n_skip;
            r_running   <= n_running;
            r_receiving <= n_receiving;
            r_bytes_left <= n_bytes_left;
            r_pend_len  <= n_pend_len;
            r_bus       <= n_bus;
            r_out_valid <= n_out_valid;
        end
        r_read_nack <= n_read_nack;
        r_cw        <= n_cw;
        r_rst       <= n_rst;
        r_tw        <= n_tw;
        r_tx        <= n_tx;
        r_rv        <= n_rv;
        r_rx        <= n_rx;
        r_rd        <= n_rd;
        r_drop      <= n_drop;
        r_o_cw      <= n_o_cw;
        r_o_bus     <= n_o_bus;
        r_o_rst     <= n_o_rst;
        r_o_tw      <= n_o_tw;
        r_o_tx      <= n_o_tx;
        r_o_rv      <= n_o_rv;
        r_o_rx      <= n_o_rx;
        r_o_rd      <= n_o_rd;
        r_o_busy    <= n_o_busy;
        r_o_drop    <= n_o_drop;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_ctrl_write    = r_o_cw;
    assign o_ctrl_master   = r_o_bus.master;
    assign o_ctrl_transmit = r_o_bus.transmit;
    assign o_ctrl_nack     = r_o_bus.nack;
    assign o_ctrl_restart  = r_o_rst;
    assign o_tx_write      = r_o_tw;
    assign o_tx_byte       = r_o_tx;
    assign o_rx_valid      = r_o_rv;
    assign o_rx_out        = r_o_rx;
    assign o_rx_done       = r_o_rd;
    assign o_busy_res      = r_o_busy;
    assign o_dropped       = r_o_drop;

    // a write never lands on an entry that is still waiting to be popped
    `ASSERT_RST(a_no_overwrite, i_clk, i_rst_n, w_we |-> (w_head_nxt != r_tail), "queue overwrite")
    // the ram is only read while it holds something
    `ASSERT_RST(a_read_nonempty, i_clk, i_rst_n, w_rd_en |-> (r_head != r_tail), "read of empty queue")
    // a read in progress keeps the sequencer running
    `ASSERT_RST(a_recv_running, i_clk, i_rst_n, r_receiving |-> r_running, "receiving while idle")
    // last byte of a read always rewrites the bus control
    `ASSERT_RST(a_done_ctrl, i_clk, i_rst_n, (o_out_valid && o_rx_done) |-> (o_rx_valid && o_ctrl_write), "rx done without control write")
    // reset empties the output register
    `ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

`default_nettype wire

FILE: sv/i2cmcq_ram.sv
// generic single port write, registered read ram
`timescale 1ns / 1ps
`default_nettype none

module i2cmcq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
